>>> rtl/e80dc_pkg.sv
// Package for the extended/double converter: request and result structs,
// format constants and the leading-one helper. No dependencies.
package e80dc_pkg;

  typedef struct packed {
    logic        op;
    logic [63:0] ext_mantissa;
    logic [15:0] ext_sign_exponent;
    logic [63:0] double_bits;
  } req_t;

  typedef struct packed {
    logic [63:0] out_double_bits;
    logic [63:0] out_ext_mantissa;
    logic [15:0] out_ext_sign_exponent;
  } res_t;

  localparam logic        OP_EXT_TO_DBL = 1'b0;
  localparam logic        OP_DBL_TO_EXT = 1'b1;
  localparam logic [14:0] EXT_EXP_MAX   = 15'h7FFF;
  localparam logic [10:0] DBL_EXP_MAX   = 11'h7FF;
  localparam logic [63:0] DBL_QNAN      = 64'h7FF8000000000000;

  // Index of the highest set bit (0 when none).
  function automatic logic [5:0] msb_index(input logic [63:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

>>> rtl/e80dc_ext_to_dbl.sv
// Extended to double conversion: normalize, round to 53 bits, rebias,
// round again into the subnormal range. Uses e80dc_pkg.
module e80dc_ext_to_dbl (
  input  logic [63:0] mant,
  input  logic [15:0] se,
  output logic [63:0] dbl
);
  import e80dc_pkg::*;

  logic        sign;
  logic [14:0] ex;
  logic [5:0]  p;
  logic [63:0] norm;
  logic [10:0] rem;
  logic [52:0] q;
  logic [53:0] qr;
  logic        up;
  logic [52:0] m;
  logic signed [17:0] bexp;
  logic [6:0]  sh;
  logic [53:0] mx;
  logic [52:0] sq;
  logic [53:0] srem;
  logic [53:0] half;
  logic        sup;

  always_comb begin
    sign = se[15];
    ex   = se[14:0];
    p    = msb_index(mant);
    // Normalize so the leading one sits at bit 63.
    norm = mant << (6'd63 - p);
    q    = norm[63:11];
    rem  = norm[10:0];
    up   = rem[10] && ((rem[9:0] != 10'd0) || q[0]);
    qr   = {1'b0, q} + 54'(up);
    m    = qr[53] ? qr[53:1] : qr[52:0];
    // Biased exponent = ex - 16446 + p + 1023 (+1 on carry).
    bexp = 18'(ex) - 18'sd16446 + 18'(p) + 18'sd1023 + 18'(qr[53]);
    // Subnormal path: shift right by 1 - bexp with nearest-even.
    // Shifts past 54 bits leave less than half an ulp, so flush to zero.
    sh   = (bexp < -18'sd53) ? 7'd64 : 7'(18'sd1 - bexp);
    mx   = {1'b0, m};
    if (sh >= 7'd64) begin
      sq   = 53'd0;
      srem = 54'd0;
      half = 54'd0;
      sup  = 1'b0;
    end else begin
      sq   = 53'(mx >> sh);
      srem = mx & ((54'd1 << sh) - 54'd1);
      half = 54'd1 << (sh - 7'd1);
      sup  = (srem > half) || ((srem == half) && sq[0]);
    end
    if (ex == EXT_EXP_MAX) begin
      dbl = (mant[62:0] != 63'd0) ? DBL_QNAN : {sign, DBL_EXP_MAX, 52'd0};
    end else if (mant == 64'd0) begin
      dbl = {sign, 63'd0};
    end else if (bexp >= 18'sd2047) begin
      dbl = {sign, DBL_EXP_MAX, 52'd0};
    end else if (bexp >= 18'sd1) begin
      dbl = {sign, bexp[10:0], m[51:0]};
    end else begin
      dbl = {sign, 63'(sq + 53'(sup))};
    end
  end

endmodule

>>> rtl/e80dc_dbl_to_ext.sv
// Double to extended conversion: rebias, normalize subnormals, explicit
// integer bit. Uses e80dc_pkg.
module e80dc_dbl_to_ext (
  input  logic [63:0] dbl,
  output logic [63:0] mant,
  output logic [15:0] se
);
  import e80dc_pkg::*;

  logic        sign;
  logic [10:0] ex;
  logic [51:0] frac;
  logic [5:0]  p;
  logic [5:0]  sh;
  logic [52:0] nf;

  always_comb begin
    sign = dbl[63];
    ex   = dbl[62:52];
    frac = dbl[51:0];
    p    = msb_index({12'd0, frac});
    sh   = 6'd52 - p;
    nf   = {1'b0, frac} << sh;
    if (ex == 11'd0 && frac == 52'd0) begin
      se = {sign, 15'd0};
      mant = 64'd0;
    end else if (ex == DBL_EXP_MAX) begin
      se = {sign, EXT_EXP_MAX};
      mant = {1'b1, frac, 11'd0};
    end else if (ex == 11'd0) begin
      se = {sign, 15'(15'd15361 - 15'(sh))};
      mant = {1'b1, nf[51:0], 11'd0};
    end else begin
      se = {sign, 15'(15'(ex) + 15'd15360)};
      mant = {1'b1, frac, 11'd0};
    end
  end

endmodule

>>> rtl/ext80_double_convert_top.sv
// Top level of the extended/double converter: input register, both
// converters, result register. Uses e80dc_pkg and the two converters.
//
// Usage:
//   Drive req and pulse start; a request is taken on any edge where start
//   is high and busy is low. busy is always low, so one request per cycle.
//   The result appears on res with done high exactly one cycle, once the
//   request has passed the input register and then the result register;
//   it is taken at the edge where done is high.
//   Throughput is one request per cycle, set by the single combinational
//   pass between the two registers.
//   Fields not meaning anything for the chosen op read as zero.
//   The receiver cannot stall; results must be taken when done is high.
//   Synchronous rst clears the valid bits; no request is in flight after.
module ext80_double_convert_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  e80dc_pkg::req_t   req,
  output logic              done,
  output e80dc_pkg::res_t   res
);
  import e80dc_pkg::*;

  req_t        req_q;
  logic        vld_q;
  logic [63:0] e2d;
  logic [63:0] d2e_m;
  logic [15:0] d2e_se;

  assign busy = 1'b0;

  // Capture the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
    if (start && !busy) req_q <= req;
  end

  e80dc_ext_to_dbl u_e2d (
    .mant(req_q.ext_mantissa), .se(req_q.ext_sign_exponent), .dbl(e2d)
  );
  e80dc_dbl_to_ext u_d2e (.dbl(req_q.double_bits), .mant(d2e_m), .se(d2e_se));

  // Register the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_q;
    end
    if (req_q.op == OP_DBL_TO_EXT) begin
      res <= '{out_double_bits: 64'd0, out_ext_mantissa: d2e_m,
               out_ext_sign_exponent: d2e_se};
    end else begin
      res <= '{out_double_bits: e2d, out_ext_mantissa: 64'd0,
               out_ext_sign_exponent: 16'd0};
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    vld_q |=> done) else $error("result lost");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !vld_q |=> !done) else $error("spurious result");
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.out_double_bits == 64'd0 || res.out_ext_mantissa == 64'd0))
    else $error("both result fields set");

endmodule

>>> sim/ext80_double_convert_top_test.sv
// Testbench for ext80_double_convert_top: drives extended/double conversion
// requests and checks each result against an integer-exact predictor.
// Depends on e80dc_pkg and the converter RTL.
`timescale 1ns / 100ps

module ext80_double_convert_top_test;
  import e80dc_pkg::*;

  // Predictor of one conversion result, plus the queue of pending results.
  class conv_scoreboard;
    res_t pending[$];
    int   errors;

    function automatic int top_one(logic [63:0] v);
      int p;
      p = 0;
      for (int i = 0; i < 64; i++) if (v[i]) p = i;
      return p;
    endfunction

    // Shift right with round to nearest, ties to even.
    function automatic logic [63:0] rne_shift(logic [63:0] v, int s);
      logic [63:0] q, rem, half;
      if (s <= 0) return v;
      if (s >= 64) return 64'd0;
      q = v >> s;
      rem = v & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      return q;
    endfunction

    function automatic logic [63:0] ext_to_dbl(logic [63:0] mant, logic [15:0] se);
      logic [63:0] sgn, m;
      int ex, p, e0, q, bexp;
      sgn = {se[15], 63'd0};
      ex = se[14:0];
      if (se[14:0] == EXT_EXP_MAX) begin
        if (mant[62:0] != 63'd0) return DBL_QNAN;
        return sgn | 64'h7FF0000000000000;
      end
      if (mant == 64'd0) return sgn;
      p = top_one(mant);
      e0 = ex - 16446;
      m = mant;
      if (p > 52) begin
        m = rne_shift(mant, p - 52);
        e0 += p - 52;
        if (m[53]) begin
          m = m >> 1;
          e0 += 1;
        end
      end
      q = top_one(m);
      if (q < 52) begin
        m = m << (52 - q);
        e0 -= 52 - q;
      end
      bexp = e0 + 52 + 1023;
      if (bexp >= 2047) return sgn | 64'h7FF0000000000000;
      if (bexp >= 1) return sgn | {1'b0, 11'(bexp), m[51:0]};
      return sgn | rne_shift(m, 1 - bexp);
    endfunction

    function automatic res_t convert(req_t r);
      res_t o;
      logic [10:0] ex;
      logic [51:0] frac;
      logic [63:0] f;
      int sh, e;
      o = '0;
      if (r.op == OP_DBL_TO_EXT) begin
        ex = r.double_bits[62:52];
        frac = r.double_bits[51:0];
        if (ex == 11'd0 && frac == 52'd0) begin
          o.out_ext_sign_exponent = {r.double_bits[63], 15'd0};
        end else if (ex == DBL_EXP_MAX) begin
          o.out_ext_sign_exponent = {r.double_bits[63], EXT_EXP_MAX};
          o.out_ext_mantissa = {1'b1, frac, 11'd0};
        end else if (ex == 11'd0) begin
          sh = 52 - top_one({12'd0, frac});
          f = {12'd0, frac} << sh;
          e = 1 - sh - 1023 + 16383;
          o.out_ext_sign_exponent = {r.double_bits[63], 15'(e)};
          o.out_ext_mantissa = {1'b1, f[51:0], 11'd0};
        end else begin
          e = int'(ex) - 1023 + 16383;
          o.out_ext_sign_exponent = {r.double_bits[63], 15'(e)};
          o.out_ext_mantissa = {1'b1, frac, 11'd0};
        end
      end else begin
        o.out_double_bits = ext_to_dbl(r.ext_mantissa, r.ext_sign_exponent);
      end
      return o;
    endfunction

    function void note_request(req_t r);
      pending.push_back(convert(r));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.out_double_bits !== want.out_double_bits) begin
        $display("%0t: out_double_bits expected %h actual %h", $time,
                 want.out_double_bits, got.out_double_bits);
        errors++;
      end
      if (got.out_ext_mantissa !== want.out_ext_mantissa) begin
        $display("%0t: out_ext_mantissa expected %h actual %h", $time,
                 want.out_ext_mantissa, got.out_ext_mantissa);
        errors++;
      end
      if (got.out_ext_sign_exponent !== want.out_ext_sign_exponent) begin
        $display("%0t: out_ext_sign_exponent expected %h actual %h", $time,
                 want.out_ext_sign_exponent, got.out_ext_sign_exponent);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  req_t req = '0;
  res_t res;
  int   idle_pct = 0;
  conv_scoreboard sb = new();

  ext80_double_convert_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .res(res)
  );

  always #10 clk = ~clk;

  // Note each accepted request and check each strobed result.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(req);
      if (done) sb.check_result(res);
    end
  end

  // Present one request, idling first at random, and hold until taken.
  task automatic send_request(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_ext(logic [63:0] m, logic [15:0] se);
    req_t r;
    r = '0;
    r.op = OP_EXT_TO_DBL;
    r.ext_mantissa = m;
    r.ext_sign_exponent = se;
    r.double_bits = rand64();
    send_request(r);
  endtask

  task automatic send_dbl(logic [63:0] d);
    req_t r;
    r = '0;
    r.op = OP_DBL_TO_EXT;
    r.double_bits = d;
    r.ext_mantissa = rand64();
    r.ext_sign_exponent = 16'($urandom);
    send_request(r);
  endtask

  // Random request biased toward exponents near the format boundaries.
  task automatic send_random();
    logic [63:0] m, d;
    logic [14:0] ex;
    int sel;
    m = rand64();
    sel = $urandom_range(9);
    case (sel)
      0: ex = 15'($urandom_range(16383 - 1100, 16383 - 1000));
      1: ex = 15'($urandom_range(16383 + 1000, 16383 + 1030));
      2: ex = EXT_EXP_MAX;
      3: ex = 15'($urandom_range(0, 3));
      4: m = m >> $urandom_range(63);
      5: m = m | 64'h7FF;
      default: ex = 15'($urandom_range(16383 - 1080, 16383 + 1080));
    endcase
    if (sel >= 3) ex = (sel == 3) ? ex : 15'($urandom_range(16383 - 1080, 16383 + 1080));
    if ($urandom_range(7) == 0) ex = 15'($urandom);
    if ($urandom_range(1)) begin
      send_ext(m, {1'($urandom), ex});
    end else begin
      d = rand64();
      case ($urandom_range(4))
        0: d[62:52] = 11'd0;
        1: d[62:52] = DBL_EXP_MAX;
        2: d[51:0] = d[51:0] >> $urandom_range(51);
        default: ;
      endcase
      if (d[62:52] == 11'd0 && $urandom_range(1)) d[51:0] = d[51:0] >> $urandom_range(52);
      send_dbl(d);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zeros, infinities, NaNs, denormals, rounding ties, limits.
    send_ext(64'd0, 16'h0000);
    send_ext(64'd0, 16'hBFFF);
    send_ext(64'h8000000000000000, 16'h7FFF);
    send_ext(64'h0000000000000000, 16'hFFFF);
    send_ext(64'hC000000000000000, 16'hFFFF);
    send_ext(64'h0000000000000001, 16'h7FFF);
    send_ext(64'h8000000000000000, 16'h3FFF);
    send_ext(64'hFFFFFFFFFFFFFFFF, 16'hFFFE);
    send_ext(64'hFFFFFFFFFFFFF800, 16'h43FE);
    send_ext(64'h8000000000000400, 16'h3FFF);
    send_ext(64'h8000000000000C00, 16'h3FFF);
    send_ext(64'hFFFFFFFFFFFFFFFF, 16'h3BCC);
    send_ext(64'h8000000000000000, 16'h3BCC);
    send_ext(64'h8000000000000000, 16'hBBCD);
    send_ext(64'hFFFFFFFFFFFFFFFF, 16'h0000);
    send_ext(64'h0000000000000001, 16'h3C00);
    send_dbl(64'h0000000000000000);
    send_dbl(64'h8000000000000000);
    send_dbl(64'h7FF0000000000000);
    send_dbl(64'hFFF8000000000001);
    send_dbl(64'h0000000000000001);
    send_dbl(64'h800FFFFFFFFFFFFF);
    send_dbl(64'h7FEFFFFFFFFFFFFF);
    send_dbl(64'h3FF0000000000000);

    // Random phases with different sender idling.
    idle_pct = 20;
    repeat (150) send_random();
    idle_pct = 73;
    repeat (150) send_random();
    idle_pct = 0;
    repeat (150) send_random();
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
